// ===== design/periodic_task_timer_table_assert.svh =====
// Assertion macros used by the timer table top-level design file.
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ptt_pkg.sv =====
// Types and codes shared by the periodic timer table modules.
package ptt_pkg;

  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_FAULT = 3'd3;
  localparam logic [2:0] FUNC_RESET = 3'd4;
  localparam logic [2:0] FUNC_TICK  = 3'd5;

  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_FAULTED = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] runs;
    logic [31:0] countdown;
    logic [31:0] period;
  } slot_entry_t;

  typedef struct packed {
    logic we;
    logic ok;
    logic fire;
  } alu_flags_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  slot;
    logic        fired;
    logic [31:0] runs;
    logic        last;
  } result_t;

endpackage

// ===== design/ptt_slot_mem.sv =====
// Slot table memory with one write port and one registered read port.
module ptt_slot_mem
  import ptt_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  slot_entry_t       wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output slot_entry_t       rdata_o
);

  slot_entry_t mem_q [DEPTH];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ptt_slot_alu.sv =====
// Shared slot update unit: applies one command or one tick step to a slot entry.
module ptt_slot_alu
  import ptt_pkg::*;
(
  input  logic [2:0]  func_i,
  input  logic        id_valid_i,
  input  logic        full_i,
  input  logic [31:0] period_i,
  input  slot_entry_t entry_i,
  output slot_entry_t entry_o,
  output alu_flags_t  flags_o
);

  logic [31:0] dec;

  assign dec = entry_i.countdown - 32'd1;

  always_comb begin
    entry_o = entry_i;
    flags_o = '0;
    case (func_i)
      FUNC_ADD: begin
        flags_o.ok      = (period_i != 32'd0) && !full_i;
        flags_o.we      = flags_o.ok;
        entry_o.mode    = MODE_STOPPED;
        entry_o.runs    = 32'd0;
        entry_o.countdown = period_i;
        entry_o.period  = period_i;
      end
      FUNC_START: begin
        flags_o.ok        = id_valid_i && (entry_i.mode != MODE_FAULTED);
        flags_o.we        = flags_o.ok;
        entry_o.countdown = entry_i.period;
        entry_o.mode      = MODE_RUNNING;
      end
      FUNC_STOP: begin
        flags_o.ok   = id_valid_i;
        flags_o.we   = flags_o.ok;
        entry_o.mode = MODE_STOPPED;
      end
      FUNC_FAULT: begin
        flags_o.ok   = id_valid_i;
        flags_o.we   = flags_o.ok;
        entry_o.mode = MODE_FAULTED;
      end
      FUNC_RESET: begin
        flags_o.ok        = id_valid_i;
        flags_o.we        = flags_o.ok;
        entry_o.countdown = entry_i.period;
        entry_o.mode      = MODE_STOPPED;
      end
      FUNC_TICK: begin
        flags_o.ok   = 1'b1;
        flags_o.we   = (entry_i.mode == MODE_RUNNING);
        flags_o.fire = flags_o.we && (dec == 32'd0);
        if (flags_o.fire) begin
          entry_o.countdown = entry_i.period;
          entry_o.runs      = entry_i.runs + 32'd1;
        end else begin
          entry_o.countdown = dec;
        end
      end
      default: begin
        flags_o = '0;
      end
    endcase
  end

endmodule

// ===== design/periodic_task_timer_table.sv =====
// Periodic timer table top level: sequencer, result registers and slot storage.
//
//   Channel  Direction  Contents
//   s_axis   in         tuser: func; tdata: slot_id, period
//   m_axis   out        tdata: ok, result_slot, fired, runs; tlast: last
//
// A command goes from transfer to result by accept with table read, then update once the output is free.
// A tick passes every added slot in turn through the update unit, reading each one
// through the single table read port.
// A stalled output holds the scan only when a second expiry is ready to report.
// Reset clears the sequencer and the slot count; the table needs no clearing pass.
module periodic_task_timer_table
  import ptt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slot_id [2:0], period [34:3], zeros [39:35]
  input  logic [2:0]  s_axis_tuser,  // func [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // ok [0], result_slot [3:1], fired [4], runs [36:5]
  output logic        m_axis_tlast
);

  `include "periodic_task_timer_table_assert.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] slots_used_q, slots_used_d;
  logic          hold_v_q, hold_v_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;
  logic [2:0]    func_q, id_q;
  logic [31:0]   period_q;
  logic [2:0]    hold_slot_q;
  logic [31:0]   hold_runs_q;

  logic          in_acc, out_free, out_load, hold_load, stall, scan_end, id_valid, full;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  slot_entry_t   mem_rdata, alu_entry;
  alu_flags_t    alu_flags;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign id_valid = ({29'd0, id_q} < 32'(slots_used_q));
  assign full     = (slots_used_q == CW'(SLOTS));
  assign scan_end = ((CW'(idx_q) + CW'(1)) == slots_used_q);
  assign stall    = alu_flags.fire && hold_v_q && !out_free;

  ptt_slot_mem #(
    .DEPTH(SLOTS),
    .AW   (IW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(alu_entry),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  ptt_slot_alu u_alu (
    .func_i    (func_q),
    .id_valid_i(id_valid),
    .full_i    (full),
    .period_i  (period_q),
    .entry_i   (mem_rdata),
    .entry_o   (alu_entry),
    .flags_o   (alu_flags)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    slots_used_d = slots_used_q;
    hold_v_d     = hold_v_q;
    out_load     = 1'b0;
    out_d        = out_q;
    hold_load    = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = IW'(idx_q + IW'(1));
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    case (state_q)
      ST_IDLE: begin
        mem_re    = in_acc;
        mem_raddr = (s_axis_tuser == FUNC_TICK) ? '0 : IW'(s_axis_tdata[2:0]);
        idx_d     = '0;
        if (in_acc) begin
          if (s_axis_tuser == FUNC_TICK) begin
            state_d = (slots_used_q == '0) ? ST_FINISH : ST_SCAN;
          end else begin
            state_d = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        mem_waddr = (func_q == FUNC_ADD) ? IW'(slots_used_q) : IW'(id_q);
        if (out_free) begin
          mem_we   = alu_flags.we;
          out_load = 1'b1;
          out_d    = '{ok: alu_flags.ok, slot: '0, fired: 1'b0, runs: '0, last: 1'b1};
          if ((func_q == FUNC_ADD) && alu_flags.ok) begin
            out_d.slot   = 3'(slots_used_q);
            slots_used_d = slots_used_q + CW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          mem_we = alu_flags.we;
          if (alu_flags.fire) begin
            hold_load = 1'b1;
            hold_v_d  = 1'b1;
            if (hold_v_q) begin
              out_load = 1'b1;
              out_d    = '{ok: 1'b1, slot: hold_slot_q, fired: 1'b1,
                           runs: hold_runs_q, last: 1'b0};
            end
          end
          if (scan_end) begin
            state_d = ST_FINISH;
          end else begin
            mem_re = 1'b1;
            idx_d  = IW'(idx_q + IW'(1));
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hold_v_q) begin
            out_d = '{ok: 1'b1, slot: hold_slot_q, fired: 1'b1,
                      runs: hold_runs_q, last: 1'b1};
          end else begin
            out_d = '{ok: 1'b1, slot: '0, fired: 1'b0, runs: '0, last: 1'b1};
          end
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      slots_used_q <= '0;
      hold_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      slots_used_q <= slots_used_d;
      hold_v_q     <= hold_v_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      func_q   <= s_axis_tuser;
      id_q     <= s_axis_tdata[2:0];
      period_q <= s_axis_tdata[34:3];
    end
    if (hold_load) begin
      hold_slot_q <= 3'(idx_q);
      hold_runs_q <= alu_entry.runs;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q.runs, out_q.fired, out_q.slot, out_q.ok};
  assign m_axis_tlast  = out_q.last;

  `PTT_ASSERT_NOW(a_idle_no_pending, s_axis_tready, !hold_v_q,
                  "An expiry is still pending while the block is idle.")
  `PTT_ASSERT_NOW(a_count_in_range, 1'b1, slots_used_q <= CW'(SLOTS),
                  "The slot count exceeds the table depth.")
  `PTT_ASSERT_NOW(a_no_write_idle, mem_we, state_q != ST_IDLE,
                  "The slot table is written while the block is idle.")
  `PTT_ASSERT_NEXT(a_finish_done, (state_q == ST_FINISH) && out_free, state_q == ST_IDLE,
                   "A finished tick did not return the sequencer to idle.")

endmodule

// ===== tb/tb_periodic_task_timer_table.sv =====
// Self-checking testbench for the periodic timer table: directed cases, then random traffic.
module tb_periodic_task_timer_table
  import ptt_pkg::*;
();

  localparam int          SLOT_COUNT    = 8;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam logic [2:0]  FUNC_SPARE_A  = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_B  = 3'd7;
  localparam logic [31:0] PERIOD_MAX    = 32'hFFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic [31:0] period_tab    [SLOT_COUNT];
  logic [31:0] countdown_tab [SLOT_COUNT];
  logic [31:0] runs_tab      [SLOT_COUNT];
  logic [1:0]  mode_tab      [SLOT_COUNT];
  int unsigned slots_added;

  result_t     pending_results[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        no_idle_stretch;

  periodic_task_timer_table #(
    .SLOTS(SLOT_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= no_idle_stretch ? 1'b1 : ($urandom_range(99) >= 29);
  end

  task automatic predict_timer_results(input logic [2:0] func, input logic [2:0] id,
                                       input logic [31:0] period);
    result_t r;
    result_t held;
    logic    held_valid;
    logic    hit;
    r          = '0;
    r.last     = 1'b1;
    held       = '0;
    held_valid = 1'b0;
    hit        = (id < slots_added);
    if (func == FUNC_TICK) begin
      for (int i = 0; i < slots_added; i++) begin
        if (mode_tab[i] == MODE_RUNNING) begin
          countdown_tab[i] = countdown_tab[i] - 32'd1;
          if (countdown_tab[i] == 32'd0) begin
            countdown_tab[i] = period_tab[i];
            runs_tab[i]      = runs_tab[i] + 32'd1;
            if (held_valid) pending_results.push_back(held);
            held       = '0;
            held.ok    = 1'b1;
            held.slot  = i[2:0];
            held.fired = 1'b1;
            held.runs  = runs_tab[i];
            held_valid = 1'b1;
          end
        end
      end
      if (held_valid) begin
        held.last = 1'b1;
        pending_results.push_back(held);
      end else begin
        r.ok = 1'b1;
        pending_results.push_back(r);
      end
    end else begin
      case (func)
        FUNC_ADD: begin
          if (period != 32'd0 && slots_added < SLOT_COUNT) begin
            period_tab[slots_added]    = period;
            countdown_tab[slots_added] = period;
            runs_tab[slots_added]      = 32'd0;
            mode_tab[slots_added]      = MODE_STOPPED;
            r.ok   = 1'b1;
            r.slot = slots_added[2:0];
            slots_added++;
          end
        end
        FUNC_START: begin
          if (hit && mode_tab[id] != MODE_FAULTED) begin
            countdown_tab[id] = period_tab[id];
            mode_tab[id]      = MODE_RUNNING;
            r.ok              = 1'b1;
          end
        end
        FUNC_STOP: begin
          if (hit) begin
            mode_tab[id] = MODE_STOPPED;
            r.ok         = 1'b1;
          end
        end
        FUNC_FAULT: begin
          if (hit) begin
            mode_tab[id] = MODE_FAULTED;
            r.ok         = 1'b1;
          end
        end
        FUNC_RESET: begin
          if (hit) begin
            countdown_tab[id] = period_tab[id];
            mode_tab[id]      = MODE_STOPPED;
            r.ok              = 1'b1;
          end
        end
        default: begin
        end
      endcase
      pending_results.push_back(r);
    end
  endtask

  // Commands are predicted as they are accepted, before results of the same edge are checked.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_timer_results(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[34:3]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("Result transfer with no result expected");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, m_axis_tdata[0]);
          mismatch_count++;
        end
        if (m_axis_tdata[3:1] !== want.slot) begin
          $error("result_slot: expected %0d, actual %0d", want.slot, m_axis_tdata[3:1]);
          mismatch_count++;
        end
        if (m_axis_tdata[4] !== want.fired) begin
          $error("fired: expected %0d, actual %0d", want.fired, m_axis_tdata[4]);
          mismatch_count++;
        end
        if (m_axis_tdata[36:5] !== want.runs) begin
          $error("runs: expected %0d, actual %0d", want.runs, m_axis_tdata[36:5]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_command(input logic [2:0] func, input logic [2:0] id,
                              input logic [31:0] period);
    if (!no_idle_stretch && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'b0, period, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_empty_table();
    send_command(FUNC_TICK, 3'd0, 32'd0);
    send_command(FUNC_START, 3'd0, 32'd5);
    send_command(FUNC_STOP, 3'd5, 32'd0);
    send_command(FUNC_FAULT, 3'd3, 32'd0);
    send_command(FUNC_RESET, 3'd7, PERIOD_MAX);
    send_command(FUNC_ADD, 3'd0, 32'd0);
    send_command(FUNC_SPARE_A, 3'd2, 32'd1);
    send_command(FUNC_SPARE_B, 3'd7, PERIOD_MAX);
  endtask

  task automatic test_add_and_run();
    send_command(FUNC_ADD, 3'd7, 32'd1);
    send_command(FUNC_ADD, 3'd0, PERIOD_MAX);
    send_command(FUNC_START, 3'd0, 32'd0);
    send_command(FUNC_START, 3'd1, 32'd0);
    send_command(FUNC_TICK, 3'd0, 32'd0);
  endtask

  task automatic test_full_table();
    send_command(FUNC_ADD, 3'd0, 32'd2);
    send_command(FUNC_ADD, 3'd0, 32'd3);
    send_command(FUNC_ADD, 3'd0, 32'd1);
    send_command(FUNC_ADD, 3'd0, 32'd2);
    send_command(FUNC_ADD, 3'd0, 32'd1);
    send_command(FUNC_ADD, 3'd0, 32'd4);
    send_command(FUNC_ADD, 3'd0, 32'd5);
  endtask

  task automatic test_fault_handling();
    send_command(FUNC_FAULT, 3'd2, 32'd0);
    send_command(FUNC_START, 3'd2, 32'd0);
    send_command(FUNC_RESET, 3'd2, 32'd0);
    send_command(FUNC_START, 3'd2, 32'd0);
    send_command(FUNC_STOP, 3'd0, 32'd0);
    send_command(FUNC_TICK, 3'd0, 32'd0);
  endtask

  // Ticks dominate so that several slots expire together; faults stay until a stop or reset.
  task automatic test_random_traffic();
    int unsigned pick;
    logic [2:0]  func;
    logic [31:0] period;
    for (int n = 0; n < 335; n++) begin
      no_idle_stretch = (n >= 120 && n < 200);
      pick   = $urandom_range(99);
      period = $urandom;
      if (pick < 35) func = FUNC_TICK;
      else if (pick < 60) func = FUNC_START;
      else if (pick < 70) func = FUNC_STOP;
      else if (pick < 76) func = FUNC_FAULT;
      else if (pick < 86) func = FUNC_RESET;
      else if (pick < 95) begin
        func = FUNC_ADD;
        if ($urandom_range(3) == 0) period = 32'd0;
      end else func = $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
      send_command(func, 3'($urandom_range(7)), period);
    end
    no_idle_stretch = 1'b0;
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    m_axis_tready   = 1'b0;
    slots_added     = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    no_idle_stretch = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_add_and_run();
    test_full_table();
    test_fault_handling();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
